[rtl/core/shp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_pkg
// Shared types, codes and widths of the stall homing sequencer.
// ----------------------------------------------------------------------------
package shp_pkg;

  localparam int unsigned POS_BITS   = 32;
  localparam int unsigned WIDE_BITS  = (POS_BITS + 2 > 33) ? POS_BITS + 2 : 33;
  localparam int unsigned LIMIT_BITS = 31;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SEEK1  = 3'd1;
  localparam logic [2:0] PH_SEEK2  = 3'd2;
  localparam logic [2:0] PH_CENTER = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;
  localparam logic [2:0] PH_ABORT  = 3'd5;

  localparam logic [1:0] ST_NONE     = 2'd0;
  localparam logic [1:0] ST_DONE     = 2'd1;
  localparam logic [1:0] ST_OVERCUR  = 2'd2;
  localparam logic [1:0] ST_TIMEOUT  = 2'd3;

  localparam logic MODE_START = 1'b0;

  localparam logic [2:0] REG_HOMING_SPEED     = 3'd0;
  localparam logic [2:0] REG_STALL_CURRENT    = 3'd1;
  localparam logic [2:0] REG_SAFE_CURRENT     = 3'd2;
  localparam logic [2:0] REG_LIMIT_MARGIN     = 3'd3;
  localparam logic [2:0] REG_ARRIVE_TOLERANCE = 3'd4;
  localparam logic [2:0] REG_WAIT_TICKS_MAX   = 3'd5;
  localparam logic [2:0] REG_APPLY_SETTINGS   = 3'd6;

  localparam logic [12:0] RST_HOMING_SPEED     = 13'd200;
  localparam logic [14:0] RST_STALL_CURRENT    = 15'd4000;
  localparam logic [14:0] RST_SAFE_CURRENT     = 15'd10000;
  localparam logic [15:0] RST_LIMIT_MARGIN     = 16'd3277;
  localparam logic [15:0] RST_ARRIVE_TOLERANCE = 16'd3277;
  localparam logic [15:0] RST_WAIT_TICKS_MAX   = 16'd1000;
  localparam logic        RST_APPLY_SETTINGS   = 1'b1;

  typedef logic signed [POS_BITS-1:0]  pos_t;
  typedef logic signed [WIDE_BITS-1:0] wide_t;

  typedef struct packed {
    logic [12:0] homing_speed;
    logic [14:0] stall_current;
    logic [14:0] safe_current;
    logic [15:0] limit_margin;
    logic [15:0] arrive_tolerance;
    logic [15:0] wait_ticks_max;
    logic        apply_settings;
  } cfg_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] motor_current;
    logic [31:0] motor_position;
  } item_t;

  typedef struct packed {
    logic [13:0]           velocity_command;
    logic [31:0]           position_command;
    logic                  position_command_valid;
    logic [2:0]            phase;
    logic [1:0]            run_status;
    logic [31:0]           found_zero;
    logic [LIMIT_BITS-1:0] found_limit;
    logic                  apply_homing;
  } result_t;

endpackage

[rtl/core/stall_homing_sequencer_top.sv]
`timescale 1ns / 1ps
// a beat is held in the input register, its result in the output register
// throughput: one item per cycle, limited only by the output register
// being taken; the input register and the output register form a 2-deep pipe
// reset: asynchronous, active low; phase idle, homing state cleared, config
// registers at their reset values, both channels empty
// ----------------------------------------------------------------------------
// stall_homing_sequencer_top
// Sensorless hard-stop homing sequencer with config port and beat handshake.
// ----------------------------------------------------------------------------
module stall_homing_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic signed [15:0] motor_current_i,
  input  logic signed [31:0] motor_position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [13:0] velocity_command_o,
  output logic signed [31:0] position_command_o,
  output logic        position_command_valid_o,
  output logic [2:0]  phase_o,
  output logic [1:0]  run_status_o,
  output logic signed [31:0] found_zero_o,
  output logic [30:0] found_limit_o,
  output logic        apply_homing_o
);

  shp_pkg::cfg_t    cfg_q;
  shp_pkg::item_t   in_item_q;
  logic             in_vld_q;
  shp_pkg::result_t res_d, res_q;
  logic             out_vld_q;
  logic             adv, step;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.homing_speed     <= shp_pkg::RST_HOMING_SPEED;
      cfg_q.stall_current    <= shp_pkg::RST_STALL_CURRENT;
      cfg_q.safe_current     <= shp_pkg::RST_SAFE_CURRENT;
      cfg_q.limit_margin     <= shp_pkg::RST_LIMIT_MARGIN;
      cfg_q.arrive_tolerance <= shp_pkg::RST_ARRIVE_TOLERANCE;
      cfg_q.wait_ticks_max   <= shp_pkg::RST_WAIT_TICKS_MAX;
      cfg_q.apply_settings   <= shp_pkg::RST_APPLY_SETTINGS;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        shp_pkg::REG_HOMING_SPEED:     cfg_q.homing_speed     <= cfg_data_i[12:0];
        shp_pkg::REG_STALL_CURRENT:    cfg_q.stall_current    <= cfg_data_i[14:0];
        shp_pkg::REG_SAFE_CURRENT:     cfg_q.safe_current     <= cfg_data_i[14:0];
        shp_pkg::REG_LIMIT_MARGIN:     cfg_q.limit_margin     <= cfg_data_i;
        shp_pkg::REG_ARRIVE_TOLERANCE: cfg_q.arrive_tolerance <= cfg_data_i;
        shp_pkg::REG_WAIT_TICKS_MAX:   cfg_q.wait_ticks_max   <= cfg_data_i;
        shp_pkg::REG_APPLY_SETTINGS:   cfg_q.apply_settings   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign adv        = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && adv;
  assign in_ready_o = adv || !in_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q.mode           <= mode_i;
      in_item_q.motor_current  <= motor_current_i;
      in_item_q.motor_position <= motor_position_i;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  shp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .cfg_i    (cfg_q),
    .result_o (res_d)
  );

  assign out_valid_o              = out_vld_q;
  assign velocity_command_o       = res_q.velocity_command;
  assign position_command_o       = res_q.position_command;
  assign position_command_valid_o = res_q.position_command_valid;
  assign phase_o                  = res_q.phase;
  assign run_status_o             = res_q.run_status;
  assign found_zero_o             = res_q.found_zero;
  assign found_limit_o            = res_q.found_limit;
  assign apply_homing_o           = res_q.apply_homing;

endmodule

[rtl/core/shp_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_core
// Homing state and the single-pass step logic for one beat.
// ----------------------------------------------------------------------------
module shp_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  shp_pkg::item_t   item_i,
  input  shp_pkg::cfg_t    cfg_i,
  output shp_pkg::result_t result_o
);

  logic [2:0]                     phase_q, phase_d;
  shp_pkg::pos_t                  first_q, first_d;
  logic                           first_vld_q, first_vld_d;
  shp_pkg::pos_t                  centre_q, centre_d;
  logic [shp_pkg::LIMIT_BITS-1:0] limit_q, limit_d;
  logic                           reversed_q, reversed_d;
  logic [15:0]                    wait_q, wait_d;
  logic [1:0]                     status_q, status_d;
  logic                           applied_q, applied_d;

  logic [15:0]    cur_mag;
  shp_pkg::pos_t  pos;
  shp_pkg::wide_t sum, half, half_abs, half_m, err, err_abs;
  shp_pkg::pos_t  mid;
  logic [shp_pkg::LIMIT_BITS-1:0] half_sat;
  logic [15:0]    wait_inc;
  logic           pulse;
  logic [13:0]    spd;

  always_comb begin
    cur_mag  = item_i.motor_current[15] ? (~item_i.motor_current + 16'd1)
                                        : item_i.motor_current;
    pos      = shp_pkg::POS_BITS'($signed(item_i.motor_position));

    // stop pair: floor midpoint and half span less margin
    sum      = shp_pkg::WIDE_BITS'(first_q) + shp_pkg::WIDE_BITS'(pos);
    mid      = shp_pkg::POS_BITS'(sum >>> 1);
    half     = shp_pkg::WIDE_BITS'(first_q) - shp_pkg::WIDE_BITS'(mid);
    half_abs = half[shp_pkg::WIDE_BITS-1] ? -half : half;
    half_m   = half_abs - $signed({{(shp_pkg::WIDE_BITS-16){1'b0}}, cfg_i.limit_margin});
    if (half_m[shp_pkg::WIDE_BITS-1]) begin
      half_sat = '0;
    end else if (|half_m[shp_pkg::WIDE_BITS-2:shp_pkg::LIMIT_BITS]) begin
      half_sat = '1;
    end else begin
      half_sat = half_m[shp_pkg::LIMIT_BITS-1:0];
    end

    err      = shp_pkg::WIDE_BITS'(pos) - shp_pkg::WIDE_BITS'(centre_q);
    err_abs  = err[shp_pkg::WIDE_BITS-1] ? -err : err;
    wait_inc = (wait_q != 16'hFFFF) ? wait_q + 16'd1 : wait_q;

    phase_d     = phase_q;
    first_d     = first_q;
    first_vld_d = first_vld_q;
    centre_d    = centre_q;
    limit_d     = limit_q;
    reversed_d  = reversed_q;
    wait_d      = wait_q;
    status_d    = status_q;
    applied_d   = applied_q;
    pulse       = 1'b0;

    if (item_i.mode == shp_pkg::MODE_START) begin
      phase_d     = shp_pkg::PH_SEEK1;
      first_d     = '0;
      first_vld_d = 1'b0;
      centre_d    = '0;
      limit_d     = '0;
      reversed_d  = 1'b0;
      wait_d      = '0;
      status_d    = shp_pkg::ST_NONE;
      applied_d   = 1'b0;
    end else if (phase_q == shp_pkg::PH_SEEK1 || phase_q == shp_pkg::PH_SEEK2) begin
      if (cur_mag > {1'b0, cfg_i.safe_current}) begin
        phase_d  = shp_pkg::PH_ABORT;
        status_d = shp_pkg::ST_OVERCUR;
      end else if (cur_mag >= {1'b0, cfg_i.stall_current}) begin
        if (!first_vld_q) begin
          first_d     = pos;
          first_vld_d = 1'b1;
          reversed_d  = 1'b1;
          phase_d     = shp_pkg::PH_SEEK2;
        end else begin
          centre_d = mid;
          limit_d  = half_sat;
          wait_d   = '0;
          phase_d  = shp_pkg::PH_CENTER;
        end
      end
    end else if (phase_q == shp_pkg::PH_CENTER) begin
      if (err_abs <= shp_pkg::WIDE_BITS'(cfg_i.arrive_tolerance)) begin
        phase_d   = shp_pkg::PH_DONE;
        status_d  = shp_pkg::ST_DONE;
        applied_d = cfg_i.apply_settings;
        pulse     = cfg_i.apply_settings;
      end else begin
        wait_d = wait_inc;
        if (wait_inc >= cfg_i.wait_ticks_max) begin
          phase_d   = shp_pkg::PH_DONE;
          status_d  = shp_pkg::ST_TIMEOUT;
          applied_d = cfg_i.apply_settings;
          pulse     = cfg_i.apply_settings;
        end
      end
    end

    spd = {1'b0, cfg_i.homing_speed};
    result_o = '0;
    if (phase_d == shp_pkg::PH_SEEK1 || phase_d == shp_pkg::PH_SEEK2) begin
      result_o.velocity_command = reversed_d ? (~spd + 14'd1) : spd;
    end
    if (phase_d == shp_pkg::PH_CENTER) begin
      result_o.position_command       = 32'($signed(centre_d));
      result_o.position_command_valid = 1'b1;
    end else if (phase_d == shp_pkg::PH_DONE) begin
      result_o.position_command       = applied_d ? 32'd0 : 32'($signed(centre_d));
      result_o.position_command_valid = 1'b1;
    end
    result_o.phase        = phase_d;
    result_o.run_status   = status_d;
    result_o.found_zero   = 32'($signed(centre_d));
    result_o.found_limit  = limit_d;
    result_o.apply_homing = pulse;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= shp_pkg::PH_IDLE;
      first_q     <= '0;
      first_vld_q <= 1'b0;
      centre_q    <= '0;
      limit_q     <= '0;
      reversed_q  <= 1'b0;
      wait_q      <= '0;
      status_q    <= shp_pkg::ST_NONE;
      applied_q   <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      first_q     <= first_d;
      first_vld_q <= first_vld_d;
      centre_q    <= centre_d;
      limit_q     <= limit_d;
      reversed_q  <= reversed_d;
      wait_q      <= wait_d;
      status_q    <= status_d;
      applied_q   <= applied_d;
    end
  end

endmodule

[rtl/core/shp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_checker
// Port-level checks of the homing sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module shp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [13:0] velocity_command_o,
  input logic [31:0] position_command_o,
  input logic        position_command_valid_o,
  input logic [2:0]  phase_o,
  input logic [1:0]  run_status_o,
  input logic        apply_homing_o
);

  // result beat holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(phase_o))
    else $error("result beat dropped while stalled");

  // apply pulse only with a zero target in the done phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && apply_homing_o |-> phase_o == shp_pkg::PH_DONE &&
      position_command_valid_o && position_command_o == 32'd0)
    else $error("apply pulse outside done phase");

  // drive only while seeking
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && velocity_command_o != 14'd0 |->
      phase_o == shp_pkg::PH_SEEK1 || phase_o == shp_pkg::PH_SEEK2)
    else $error("velocity command outside seek");

  // abort carries overcurrent status and no target
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && phase_o == shp_pkg::PH_ABORT |->
      run_status_o == shp_pkg::ST_OVERCUR && !position_command_valid_o)
    else $error("abort phase inconsistent");

  // completion status only in the done phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (run_status_o == shp_pkg::ST_DONE ||
      run_status_o == shp_pkg::ST_TIMEOUT) |-> phase_o == shp_pkg::PH_DONE)
    else $error("done status outside done phase");

endmodule

bind stall_homing_sequencer_top shp_checker u_shp_checker (.*);

[tb/stall_homing_sequencer_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stall_homing_sequencer_top_tb
// Self-checking bench for the stall homing sequencer. Sensor beats are queued
// by a sequencing process and offered in bursts. Each accepted beat is run
// through a cycle-free model of the homing flow, and the predicted command beat
// is compared field by field with what the block returns. The receiver stalls
// on changing patterns and holds off once for a long stretch. Register
// settings change only while the block is idle.
// ----------------------------------------------------------------------------
module stall_homing_sequencer_top_tb;
  import shp_pkg::*;

  localparam int unsigned CLK_HALF       = 4;
  localparam int unsigned RESET_CYCLES   = 12;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned HOLDOFF_AFTER  = 400;
  localparam int unsigned RANDOM_PHASES  = 12;
  localparam int unsigned PHASE_BEATS    = 125;
  localparam logic [2:0]  REG_UNMAPPED   = 3'd7;
  localparam logic        MODE_TICK      = 1'b1;
  localparam longint      LIMIT_CEIL     = 64'h7fff_ffff;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_EVERY4, RX_SPARSE} rx_style_e;

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                cfg_valid_i      = 1'b0;
  logic                cfg_ready_o;
  logic [2:0]          cfg_index_i      = '0;
  logic [15:0]         cfg_data_i       = '0;
  logic                in_valid_i       = 1'b0;
  logic                in_ready_o;
  logic                mode_i           = MODE_TICK;
  logic signed [15:0]  motor_current_i  = '0;
  logic signed [31:0]  motor_position_i = '0;
  logic                out_valid_o;
  logic                out_ready_i      = 1'b0;
  logic signed [13:0]  velocity_command_o;
  logic signed [31:0]  position_command_o;
  logic                position_command_valid_o;
  logic [2:0]          phase_o;
  logic [1:0]          run_status_o;
  logic signed [31:0]  found_zero_o;
  logic [30:0]         found_limit_o;
  logic                apply_homing_o;

  stall_homing_sequencer_top i_dut (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cfg_valid_i              (cfg_valid_i),
    .cfg_ready_o              (cfg_ready_o),
    .cfg_index_i              (cfg_index_i),
    .cfg_data_i               (cfg_data_i),
    .in_valid_i               (in_valid_i),
    .in_ready_o               (in_ready_o),
    .mode_i                   (mode_i),
    .motor_current_i          (motor_current_i),
    .motor_position_i         (motor_position_i),
    .out_valid_o              (out_valid_o),
    .out_ready_i              (out_ready_i),
    .velocity_command_o       (velocity_command_o),
    .position_command_o       (position_command_o),
    .position_command_valid_o (position_command_valid_o),
    .phase_o                  (phase_o),
    .run_status_o             (run_status_o),
    .found_zero_o             (found_zero_o),
    .found_limit_o            (found_limit_o),
    .apply_homing_o           (apply_homing_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // homing model state and register copy
  cfg_t        cfg_shadow;
  logic [2:0]  hs_phase;
  longint      hs_stop1, hs_centre, hs_limit;
  bit          hs_stop1_ok, hs_reversed, hs_applied;
  int unsigned hs_waits;
  logic [1:0]  hs_status;

  item_t       sensor_beats[$];
  result_t     predicted_commands[$];
  item_t       beat_now;
  result_t     seen_cmd, want_cmd;
  bit          beat_waiting, steady;
  int unsigned burst_left, gap_left;
  int unsigned beats_queued, beats_in, beats_out, errors, cycles;
  int unsigned n_centered, n_timeouts, n_aborts, n_settings;
  int unsigned holdoff_left, pattern_left;
  bit          holdoff_done;
  rx_style_e   rx_style;

  function automatic void homing_reset();
    cfg_shadow.homing_speed     = RST_HOMING_SPEED;
    cfg_shadow.stall_current    = RST_STALL_CURRENT;
    cfg_shadow.safe_current     = RST_SAFE_CURRENT;
    cfg_shadow.limit_margin     = RST_LIMIT_MARGIN;
    cfg_shadow.arrive_tolerance = RST_ARRIVE_TOLERANCE;
    cfg_shadow.wait_ticks_max   = RST_WAIT_TICKS_MAX;
    cfg_shadow.apply_settings   = RST_APPLY_SETTINGS;
    hs_phase    = PH_IDLE;
    hs_stop1    = 0;
    hs_stop1_ok = 1'b0;
    hs_centre   = 0;
    hs_limit    = 0;
    hs_reversed = 1'b0;
    hs_waits    = 0;
    hs_status   = ST_NONE;
    hs_applied  = 1'b0;
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] data);
    case (idx)
      REG_HOMING_SPEED:     cfg_shadow.homing_speed     = data[12:0];
      REG_STALL_CURRENT:    cfg_shadow.stall_current    = data[14:0];
      REG_SAFE_CURRENT:     cfg_shadow.safe_current     = data[14:0];
      REG_LIMIT_MARGIN:     cfg_shadow.limit_margin     = data;
      REG_ARRIVE_TOLERANCE: cfg_shadow.arrive_tolerance = data;
      REG_WAIT_TICKS_MAX:   cfg_shadow.wait_ticks_max   = data;
      REG_APPLY_SETTINGS:   cfg_shadow.apply_settings   = data[0];
      default: ;
    endcase
  endfunction

  function automatic void close_run(input logic [1:0] st);
    hs_status  = st;
    hs_phase   = PH_DONE;
    hs_applied = cfg_shadow.apply_settings;
    if (st == ST_DONE) n_centered++;
    else n_timeouts++;
  endfunction

  function automatic result_t homing_step(input item_t it);
    result_t r;
    int      cur, mag;
    longint  pos, mid, half, err, vel, pcmd;
    bit      pvalid, pulse;
    cur    = int'($signed(it.motor_current));
    mag    = (cur < 0) ? -cur : cur;
    pos    = longint'($signed(it.motor_position));
    vel    = 0;
    pcmd   = 0;
    pvalid = 1'b0;
    pulse  = 1'b0;
    if (it.mode == MODE_START) begin
      hs_phase    = PH_SEEK1;
      hs_stop1    = 0;
      hs_stop1_ok = 1'b0;
      hs_centre   = 0;
      hs_limit    = 0;
      hs_reversed = 1'b0;
      hs_waits    = 0;
      hs_status   = ST_NONE;
      hs_applied  = 1'b0;
    end else if (hs_phase == PH_SEEK1 || hs_phase == PH_SEEK2) begin
      if (mag > int'(cfg_shadow.safe_current)) begin
        hs_phase  = PH_ABORT;
        hs_status = ST_OVERCUR;
        n_aborts++;
      end else if (mag >= int'(cfg_shadow.stall_current)) begin
        if (!hs_stop1_ok) begin
          hs_stop1    = pos;
          hs_stop1_ok = 1'b1;
          hs_reversed = 1'b1;
          hs_phase    = PH_SEEK2;
        end else begin
          mid  = (hs_stop1 + pos) >>> 1;
          half = hs_stop1 - mid;
          if (half < 0) half = -half;
          half = half - longint'(cfg_shadow.limit_margin);
          if (half < 0) half = 0;
          if (half > LIMIT_CEIL) half = LIMIT_CEIL;
          hs_centre = mid;
          hs_limit  = half;
          hs_waits  = 0;
          hs_phase  = PH_CENTER;
        end
      end
    end else if (hs_phase == PH_CENTER) begin
      err = pos - hs_centre;
      if (err < 0) err = -err;
      if (err <= longint'(cfg_shadow.arrive_tolerance)) begin
        close_run(ST_DONE);
        pulse = hs_applied;
      end else begin
        if (hs_waits < 16'hffff) hs_waits++;
        if (hs_waits >= cfg_shadow.wait_ticks_max) begin
          close_run(ST_TIMEOUT);
          pulse = hs_applied;
        end
      end
    end
    if (hs_phase == PH_SEEK1 || hs_phase == PH_SEEK2)
      vel = hs_reversed ? -longint'(cfg_shadow.homing_speed) : longint'(cfg_shadow.homing_speed);
    if (hs_phase == PH_CENTER) begin
      pcmd   = hs_centre;
      pvalid = 1'b1;
    end else if (hs_phase == PH_DONE) begin
      pcmd   = hs_applied ? 0 : hs_centre;
      pvalid = 1'b1;
    end
    r.velocity_command       = vel[13:0];
    r.position_command       = pcmd[31:0];
    r.position_command_valid = pvalid;
    r.phase                  = hs_phase;
    r.run_status             = hs_status;
    r.found_zero             = hs_centre[31:0];
    r.found_limit            = hs_limit[30:0];
    r.apply_homing           = pulse;
    return r;
  endfunction

  function automatic void push_beat(input logic mode, input logic [15:0] cur,
                                    input logic [31:0] pos);
    item_t it;
    it.mode           = mode;
    it.motor_current  = cur;
    it.motor_position = pos;
    sensor_beats.push_back(it);
    beats_queued++;
  endfunction

  function automatic logic [15:0] signed_current(input int mag);
    if (mag >= 32768) return 16'h8000;
    return ($urandom_range(0, 1) == 1) ? 16'(-mag) : 16'(mag);
  endfunction

  function automatic logic [31:0] near_pos(input longint base, input int unsigned lo,
                                           input int unsigned hi);
    longint off;
    off = longint'($urandom_range(lo, hi));
    if ($urandom_range(0, 1) == 1) off = -off;
    return 32'(base + off);
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    int   stall, safe;
    stall = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(200, 9000);
    if ($urandom_range(0, 7) == 0) safe = $urandom_range(0, 32767);
    else safe = stall + $urandom_range(0, 20000);
    if (safe > 32767) safe = 32767;
    c.homing_speed     = 13'($urandom_range(0, 6000));
    c.stall_current    = 15'(stall);
    c.safe_current     = 15'(safe);
    c.limit_margin     = 16'($urandom_range(0, 16'hffff));
    c.arrive_tolerance = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 16'hffff))
                                                     : 16'($urandom_range(0, 64));
    case ($urandom_range(0, 9))
      0:       c.wait_ticks_max = 16'd0;
      1:       c.wait_ticks_max = 16'hffff;
      default: c.wait_ticks_max = 16'($urandom_range(1, 8));
    endcase
    c.apply_settings = 1'($urandom_range(0, 1));
    return c;
  endfunction

  task automatic load_config(input cfg_t c);
    logic [15:0] vals [8];
    vals[REG_HOMING_SPEED]     = 16'(c.homing_speed);
    vals[REG_STALL_CURRENT]    = 16'(c.stall_current);
    vals[REG_SAFE_CURRENT]     = 16'(c.safe_current);
    vals[REG_LIMIT_MARGIN]     = c.limit_margin;
    vals[REG_ARRIVE_TOLERANCE] = c.arrive_tolerance;
    vals[REG_WAIT_TICKS_MAX]   = c.wait_ticks_max;
    vals[REG_APPLY_SETTINGS]   = 16'(c.apply_settings);
    vals[REG_UNMAPPED]         = 16'($urandom_range(0, 16'hffff));
    for (int k = REG_HOMING_SPEED; k <= REG_UNMAPPED; k++) begin
      cfg_index_i <= 3'(k);
      cfg_data_i  <= vals[k];
      cfg_valid_i <= 1'b1;
      do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
      apply_reg(3'(k), vals[k]);
    end
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  task automatic wait_idle();
    while (beats_in != beats_queued || predicted_commands.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // one homing attempt with random content, sometimes noise or a broken run
  task automatic add_run();
    int     stall, safe, quiet_max, misses;
    longint p1, p2, mid;
    stall     = int'(cfg_shadow.stall_current);
    safe      = int'(cfg_shadow.safe_current);
    quiet_max = (stall - 1 < safe) ? stall - 1 : safe;
    if ($urandom_range(0, 9) == 0) begin
      push_beat(1'($urandom_range(0, 1)), 16'($urandom), $urandom);
      return;
    end
    push_beat(MODE_START, 16'($urandom), $urandom);
    if (quiet_max >= 0)
      repeat ($urandom_range(0, 4))
        push_beat(MODE_TICK, signed_current($urandom_range(0, quiet_max)), $urandom);
    if (stall > safe || $urandom_range(0, 7) == 0) begin
      push_beat(MODE_TICK, signed_current($urandom_range(safe + 1, 32768)), $urandom);
      push_beat(MODE_TICK, 16'($urandom), $urandom);
      return;
    end
    if ($urandom_range(0, 2) == 0) p1 = longint'($signed($urandom));
    else p1 = longint'($urandom_range(0, 2097152)) - 1048576;
    push_beat(MODE_TICK, signed_current($urandom_range(stall, safe)), 32'(p1));
    if (quiet_max >= 0)
      repeat ($urandom_range(0, 4))
        push_beat(MODE_TICK, signed_current($urandom_range(0, quiet_max)), $urandom);
    if ($urandom_range(0, 11) == 0) push_beat(MODE_START, 16'($urandom), $urandom);
    if ($urandom_range(0, 3) == 0) p2 = longint'($signed($urandom));
    else p2 = longint'($signed(near_pos(p1, 0, 4000000)));
    push_beat(MODE_TICK, signed_current($urandom_range(stall, safe)), 32'(p2));
    mid    = (p1 + p2) >>> 1;
    misses = $urandom_range(0, 5);
    repeat (misses)
      push_beat(MODE_TICK, 16'($urandom),
                near_pos(mid, int'(cfg_shadow.arrive_tolerance) + 1, 200000));
    push_beat(MODE_TICK, 16'($urandom), near_pos(mid, 0, cfg_shadow.arrive_tolerance));
    repeat ($urandom_range(0, 2)) push_beat(MODE_TICK, 16'($urandom), $urandom);
  endtask

  // sender: bursts of beats with random gaps
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      predicted_commands.push_back(homing_step(beat_now));
      beats_in++;
    end
    beat_waiting = in_valid_i && !in_ready_o;
    if (!beat_waiting) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (sensor_beats.size() > 0) begin
        beat_now = sensor_beats.pop_front();
        mode_i           <= beat_now.mode;
        motor_current_i  <= beat_now.motor_current;
        motor_position_i <= beat_now.motor_position;
        in_valid_i       <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: changing stall patterns and one long hold-off
  always @(posedge clk_i) begin
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_ready_i <= 1'b0;
    end else if (!holdoff_done && beats_out >= HOLDOFF_AFTER) begin
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        rx_style     = rx_style_e'($urandom_range(0, 3));
        pattern_left = $urandom_range(32, 200);
      end else begin
        pattern_left--;
      end
      case (rx_style)
        RX_OPEN:   out_ready_i <= 1'b1;
        RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
        RX_EVERY4: out_ready_i <= (pattern_left % 4 == 0);
        default:   out_ready_i <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, exp_v, act_v);
    end
  endtask

  // command beat checker
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      beats_out++;
      seen_cmd.velocity_command       = velocity_command_o;
      seen_cmd.position_command       = position_command_o;
      seen_cmd.position_command_valid = position_command_valid_o;
      seen_cmd.phase                  = phase_o;
      seen_cmd.run_status             = run_status_o;
      seen_cmd.found_zero             = found_zero_o;
      seen_cmd.found_limit            = found_limit_o;
      seen_cmd.apply_homing           = apply_homing_o;
      if (predicted_commands.size() == 0) begin
        errors++;
        $display("%0t: command beat 0x%0h with none predicted", $time, seen_cmd);
      end else begin
        want_cmd = predicted_commands.pop_front();
        compare_field("velocity_command", want_cmd.velocity_command, seen_cmd.velocity_command);
        compare_field("position_command", want_cmd.position_command, seen_cmd.position_command);
        compare_field("position_command_valid", want_cmd.position_command_valid,
                      seen_cmd.position_command_valid);
        compare_field("phase", want_cmd.phase, seen_cmd.phase);
        compare_field("run_status", want_cmd.run_status, seen_cmd.run_status);
        compare_field("found_zero", want_cmd.found_zero, seen_cmd.found_zero);
        compare_field("found_limit", want_cmd.found_limit, seen_cmd.found_limit);
        compare_field("apply_homing", want_cmd.apply_homing, seen_cmd.apply_homing);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d beats in, %0d out", $time, beats_in, beats_out);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    cfg_t        c;
    int unsigned phase_base;
    homing_reset();
    steady = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: idle tick, full seek, far miss, arrival, abort, restart
    push_beat(MODE_TICK,  16'h8000, 32'h8000_0000);
    push_beat(MODE_START, 16'h7fff, 32'h7fff_ffff);
    push_beat(MODE_TICK,  16'(-3999), 32'd12345);
    push_beat(MODE_TICK,  16'(-4000), 32'h7fff_ffff);
    push_beat(MODE_TICK,  16'd4000, 32'h8000_0000);
    push_beat(MODE_TICK,  16'd0, 32'h4000_0000);
    push_beat(MODE_TICK,  16'd0, 32'd0);
    push_beat(MODE_TICK,  16'd0, 32'd0);
    push_beat(MODE_START, 16'd0, 32'd0);
    push_beat(MODE_TICK,  16'd10001, 32'd0);
    push_beat(MODE_TICK,  16'd0, 32'd0);
    push_beat(MODE_START, 16'd0, 32'd0);
    push_beat(MODE_TICK,  16'd4000, 32'd100);
    push_beat(MODE_START, 16'd0, 32'd0);
    push_beat(MODE_TICK,  16'd9000, 32'(-7));
    push_beat(MODE_TICK,  16'h8000, 32'd0);
    wait_idle();

    // top speed, every tick a stop, no margin, no tolerance, zero wait
    c.homing_speed     = 13'd6000;
    c.stall_current    = 15'd0;
    c.safe_current     = 15'd32767;
    c.limit_margin     = 16'd0;
    c.arrive_tolerance = 16'd0;
    c.wait_ticks_max   = 16'd0;
    c.apply_settings   = 1'b0;
    load_config(c);
    push_beat(MODE_START, 16'd1, 32'd1);
    push_beat(MODE_TICK,  16'd0, 32'h7fff_ffff);
    push_beat(MODE_TICK,  16'd0, 32'h8000_0000);
    push_beat(MODE_TICK,  16'd0, 32'd5);
    push_beat(MODE_START, 16'd0, 32'd0);
    push_beat(MODE_TICK,  16'd32767, 32'(-3));
    push_beat(MODE_TICK,  16'd0, 32'(-4));
    push_beat(MODE_TICK,  16'd0, 32'(-4));
    wait_idle();

    // zero speed, zero safe limit, widest margin, tolerance and wait
    c.homing_speed     = 13'd0;
    c.stall_current    = 15'd32767;
    c.safe_current     = 15'd0;
    c.limit_margin     = 16'hffff;
    c.arrive_tolerance = 16'hffff;
    c.wait_ticks_max   = 16'hffff;
    c.apply_settings   = 1'b1;
    load_config(c);
    push_beat(MODE_START, 16'd0, 32'd0);
    push_beat(MODE_TICK,  16'd0, 32'd0);
    push_beat(MODE_TICK,  16'd1, 32'd0);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_config(random_config());
      steady     = ($urandom_range(0, 3) == 0);
      phase_base = beats_queued;
      while (beats_queued - phase_base < PHASE_BEATS) add_run();
      wait_idle();
    end

    $display("covered %0d sensor beats and %0d command beats over %0d register settings",
             beats_in, beats_out, n_settings);
    $display("homing runs: %0d centered, %0d arrival timeouts, %0d overcurrent aborts",
             n_centered, n_timeouts, n_aborts);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
